[src/pcr_pkg.sv]
// Shared types and codes for the packet capture ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pcr_pkg;

	localparam logic [1:0] CMD_CAPTURE = 2'd0;
	localparam logic [1:0] CMD_DRAIN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam int BYTES_PER_WORD = 8;

	typedef struct packed {
		logic capture;
		logic clear;
		logic load;
		logic read;
		logic form;
		logic empty_result;
		logic word_done;
	} pcr_cmd_t;

	typedef struct packed {
		logic ring_empty;
		logic last_word;
	} pcr_status_t;

endpackage
`default_nettype wire

[src/pcr_if.sv]
// Valid/ready channel interfaces for capture requests and drain results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pcr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [11:0] signal_length;
	logic [31:0] rx_time;

	modport source (output valid, cmd, data_byte, first_byte, last_byte, signal_length,
		rx_time, input ready);
	modport sink (input valid, cmd, data_byte, first_byte, last_byte, signal_length,
		rx_time, output ready);
endinterface

interface pcr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] packet_time;
	logic [8:0]  packet_length;
	logic [63:0] word_data;
	logic [4:0]  word_number;
	logic [3:0]  valid_bytes;
	logic        ring_empty;
	logic        last_word;
	logic [31:0] packet_total;
	logic [31:0] byte_total;

	modport source (output valid, packet_time, packet_length, word_data, word_number,
		valid_bytes, ring_empty, last_word, packet_total, byte_total, input ready);
	modport sink (input valid, packet_time, packet_length, word_data, word_number,
		valid_bytes, ring_empty, last_word, packet_total, byte_total, output ready);
endinterface
`default_nettype wire

[src/packet_capture_ring.sv]
// Top level of the packet capture ring: controller plus datapath on two channels.
// Depends on pcr_pkg, pcr_if, pcr_ctrl and pcr_datapath.
//
// Capture and clear items are taken while idle, so bytes stream in at one per clock
// while no drain runs. A drain loads the slot, then for each 64-bit word does a
// payload memory read, word forming and an output handshake, plus any output stall;
// an empty drain gives its single result in the cycle after acceptance. No input is
// taken while a drain is in progress. The payload memory holds SLOT_COUNT slots of
// ceil(MAX_PACKET_BYTES/8) words; one slot always stays free.
`timescale 1ns / 1ps
`default_nettype none
module packet_capture_ring
	import pcr_pkg::*;
#(
	parameter int SLOT_COUNT       = 32,
	parameter int MAX_PACKET_BYTES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	pcr_req_if.sink  req,
	pcr_rsp_if.source rsp
);

	pcr_cmd_t    cmd;
	pcr_status_t status;

	pcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_cmd    (req.cmd),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pcr_datapath #(
		.SLOT_COUNT       (SLOT_COUNT),
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.data_byte     (req.data_byte),
		.first_byte    (req.first_byte),
		.last_byte     (req.last_byte),
		.signal_length (req.signal_length),
		.rx_time       (req.rx_time),
		.packet_time   (rsp.packet_time),
		.packet_length (rsp.packet_length),
		.word_data     (rsp.word_data),
		.word_number   (rsp.word_number),
		.valid_bytes   (rsp.valid_bytes),
		.ring_empty    (rsp.ring_empty),
		.last_word     (rsp.last_word),
		.packet_total  (rsp.packet_total),
		.byte_total    (rsp.byte_total)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("input taken while a result is pending");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ring_empty |-> rsp.last_word && (rsp.valid_bytes == 4'd0))
		else $error("empty drain result malformed");

	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last_word |-> (rsp.valid_bytes == 4'd8))
		else $error("non-final word not full");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.last_word |=> !rsp.valid)
		else $error("result after final word");

endmodule
`default_nettype wire

[src/pcr_ctrl.sv]
// Controller for the packet capture ring: sequences capture, clear and drain.
// Depends on pcr_pkg for command codes and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none
module pcr_ctrl
	import pcr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  in_cmd,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire pcr_status_t status,
	output pcr_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_FORM = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_cmd)
						CMD_CAPTURE: cmd.capture = 1'b1;
						CMD_DRAIN: begin
							if (status.ring_empty) begin
								cmd.empty_result = 1'b1;
								state_d = ST_OUT;
							end else begin
								state_d = ST_LOAD;
							end
						end
						CMD_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_FORM;
			end
			ST_FORM: begin
				cmd.form = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.word_done = 1'b1;
					state_d = status.last_word ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[src/pcr_datapath.sv]
// Datapath of the packet capture ring: slot indices, payload and slot memories,
// byte assembly, drain word forming and totals. Depends on pcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcr_datapath
	import pcr_pkg::*;
#(
	parameter int SLOT_COUNT       = 32,
	parameter int MAX_PACKET_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pcr_cmd_t    cmd,
	output pcr_status_t      status,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	input  wire logic [11:0] signal_length,
	input  wire logic [31:0] rx_time,
	output logic [31:0]      packet_time,
	output logic [8:0]       packet_length,
	output logic [63:0]      word_data,
	output logic [4:0]       word_number,
	output logic [3:0]       valid_bytes,
	output logic             ring_empty,
	output logic             last_word,
	output logic [31:0]      packet_total,
	output logic [31:0]      byte_total
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int LEN_W  = $clog2(MAX_PACKET_BYTES + 1);
	localparam int WPS    = (MAX_PACKET_BYTES + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
	localparam int WC_W   = $clog2(WPS + 1);
	localparam int DEPTH  = SLOT_COUNT * WPS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [63:0]        pay_mem [DEPTH];
	logic [2*LEN_W-1:0] meta_mem [SLOT_COUNT];
	logic [31:0]        time_mem [SLOT_COUNT];

	logic [IDX_W-1:0]  wr_slot_q, rd_slot_q;
	logic [LEN_W-1:0]  fill_q, target_q;
	logic              drop_q;
	logic [31:0]       pkt_total_q, byte_total_q;
	logic [63:0]       asm_q;

	logic [2*LEN_W-1:0] meta_rd_q;
	logic [31:0]        time_rd_q;
	logic [63:0]        pay_rd_q;

	logic [LEN_W-1:0]  len_q, rem_q, frem_q;
	logic [31:0]       time_q;
	logic [WC_W-1:0]   wcnt_q;

	logic [31:0] out_time_q, out_pkt_q, out_byte_q;
	logic [8:0]  out_len_q;
	logic [63:0] out_data_q;
	logic [4:0]  out_wn_q;
	logic [3:0]  out_vb_q;
	logic        out_empty_q, out_last_q;

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		slot_inc = (s == IDX_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	logic              full;
	logic [LEN_W-1:0]  new_target, cap_fill, cap_target, cap_fill_next;
	logic              cap_drop, cap_store;
	logic [63:0]       cap_word;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [LEN_W-1:0]  meta_len, meta_fill;
	logic [3:0]        vb, keep;
	logic [63:0]       masked;

	always_comb begin
		full       = (slot_inc(wr_slot_q) == rd_slot_q);
		new_target = (signal_length > 12'(MAX_PACKET_BYTES)) ?
			LEN_W'(MAX_PACKET_BYTES) : LEN_W'(signal_length);
		cap_drop   = first_byte ? full : drop_q;
		cap_fill   = first_byte ? '0 : fill_q;
		cap_target = first_byte ? new_target : target_q;
		cap_store  = !cap_drop && (cap_fill < cap_target);
		cap_word   = ((cap_fill[2:0] == 3'd0) ? 64'd0 : asm_q) |
			(64'(data_byte) << {cap_fill[2:0], 3'b000});
		cap_fill_next = cap_store ? cap_fill + 1'b1 : cap_fill;
		wr_addr = ADDR_W'(ADDR_W'(wr_slot_q) * ADDR_W'(WPS)) + ADDR_W'(cap_fill >> 3);
		rd_addr = ADDR_W'(ADDR_W'(rd_slot_q) * ADDR_W'(WPS)) + ADDR_W'(wcnt_q);
		meta_len  = meta_rd_q[2*LEN_W-1:LEN_W];
		meta_fill = meta_rd_q[LEN_W-1:0];
		// bytes past the stored fill of a short frame read as zero
		vb     = (rem_q > LEN_W'(BYTES_PER_WORD)) ? 4'(BYTES_PER_WORD) : 4'(rem_q);
		keep   = (frem_q > LEN_W'(BYTES_PER_WORD)) ? 4'(BYTES_PER_WORD) : 4'(frem_q);
		for (int i = 0; i < BYTES_PER_WORD; i++) begin
			masked[i*8 +: 8] = (4'(i) < keep) ? pay_rd_q[i*8 +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && cap_store) begin
			pay_mem[wr_addr] <= cap_word;
			asm_q            <= cap_word;
		end
		if (cmd.capture && !cap_drop && last_byte) begin
			meta_mem[wr_slot_q] <= {cap_target, cap_fill_next};
		end
		if (cmd.capture && first_byte && !full) begin
			time_mem[wr_slot_q] <= rx_time;
		end
		meta_rd_q <= meta_mem[rd_slot_q];
		time_rd_q <= time_mem[rd_slot_q];
		if (cmd.read) begin
			pay_rd_q <= pay_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q    <= '0;
			rd_slot_q    <= '0;
			fill_q       <= '0;
			target_q     <= '0;
			drop_q       <= 1'b1;
			pkt_total_q  <= '0;
			byte_total_q <= '0;
		end else begin
			if (cmd.capture) begin
				if (first_byte) begin
					drop_q <= full;
					if (!full) begin
						target_q <= new_target;
						fill_q   <= '0;
					end
				end
				if (!cap_drop) begin
					fill_q <= cap_fill_next;
					if (last_byte) begin
						wr_slot_q <= slot_inc(wr_slot_q);
						drop_q    <= 1'b1;
					end
				end
			end
			if (cmd.load) begin
				pkt_total_q  <= pkt_total_q + 32'd1;
				byte_total_q <= byte_total_q + 32'(meta_len);
			end
			if (cmd.word_done && out_last_q && !out_empty_q) begin
				rd_slot_q <= slot_inc(rd_slot_q);
			end
			if (cmd.clear) begin
				wr_slot_q    <= '0;
				rd_slot_q    <= '0;
				fill_q       <= '0;
				target_q     <= '0;
				drop_q       <= 1'b1;
				pkt_total_q  <= '0;
				byte_total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q  <= meta_len;
			rem_q  <= meta_len;
			frem_q <= meta_fill;
			time_q <= time_rd_q;
			wcnt_q <= '0;
		end
		if (cmd.word_done && !out_last_q) begin
			wcnt_q <= wcnt_q + 1'b1;
			rem_q  <= (rem_q > LEN_W'(BYTES_PER_WORD)) ? rem_q - LEN_W'(BYTES_PER_WORD) : '0;
			frem_q <= (frem_q > LEN_W'(BYTES_PER_WORD)) ? frem_q - LEN_W'(BYTES_PER_WORD) : '0;
		end
		if (cmd.form) begin
			out_time_q  <= time_q;
			out_len_q   <= 9'(len_q);
			out_data_q  <= masked;
			out_wn_q    <= 5'(wcnt_q);
			out_vb_q    <= vb;
			out_empty_q <= 1'b0;
			out_last_q  <= (rem_q <= LEN_W'(BYTES_PER_WORD));
			out_pkt_q   <= pkt_total_q;
			out_byte_q  <= byte_total_q;
		end
		if (cmd.empty_result) begin
			out_time_q  <= '0;
			out_len_q   <= '0;
			out_data_q  <= '0;
			out_wn_q    <= '0;
			out_vb_q    <= '0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
			out_pkt_q   <= pkt_total_q;
			out_byte_q  <= byte_total_q;
		end
	end

	assign status.ring_empty = (rd_slot_q == wr_slot_q);
	assign status.last_word  = out_last_q;

	assign packet_time   = out_time_q;
	assign packet_length = out_len_q;
	assign word_data     = out_data_q;
	assign word_number   = out_wn_q;
	assign valid_bytes   = out_vb_q;
	assign ring_empty    = out_empty_q;
	assign last_word     = out_last_q;
	assign packet_total  = out_pkt_q;
	assign byte_total    = out_byte_q;

endmodule
`default_nettype wire

[bench/packet_capture_ring_test.sv]
// Testbench for packet_capture_ring: directed and random capture, drain and clear items.
// Depends on pcr_pkg, pcr_req_if, pcr_rsp_if and the packet_capture_ring RTL.
// Drain words are predicted per accepted item and compared in order as they arrive.
`timescale 1ns / 1ps
module packet_capture_ring_test;
	import pcr_pkg::*;

	localparam int SLOTS          = 32;
	localparam int MAX_BYTES      = 256;
	localparam int WORDS_PER_SLOT = (MAX_BYTES + 7) / 8;
	localparam int STALL_LIMIT    = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;

	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [11:0] sig;
		logic [31:0] stamp;
	} ring_item_t;

	typedef struct packed {
		logic [31:0] ptime;
		logic [8:0]  plen;
		logic [63:0] data;
		logic [4:0]  wnum;
		logic [3:0]  vbytes;
		logic        empty;
		logic        lastw;
		logic [31:0] pkt_cnt;
		logic [31:0] byte_cnt;
	} drain_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcr_req_if req_ch ();
	pcr_rsp_if rsp_ch ();

	packet_capture_ring #(
		.SLOT_COUNT(SLOTS),
		.MAX_PACKET_BYTES(MAX_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Ring state as seen from outside
	logic [63:0] ring_words [SLOTS * WORDS_PER_SLOT];
	logic [8:0]  ring_len [SLOTS];
	logic [31:0] ring_stamp [SLOTS];
	logic [4:0]  wr_slot;
	logic [4:0]  rd_slot;
	logic [8:0]  fill;
	logic [8:0]  target;
	logic        dropping;
	logic [31:0] pkt_total;
	logic [31:0] byte_total;

	drain_word_t expected_words [$];
	int errors = 0;
	int items_sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_ring();
		wr_slot = '0;
		rd_slot = '0;
		fill = '0;
		target = '0;
		dropping = 1'b1;
		pkt_total = '0;
		byte_total = '0;
	endtask

	task automatic push_word(input logic [31:0] ptime, input logic [8:0] plen,
		input logic [63:0] data, input logic [4:0] wnum, input logic [3:0] vbytes,
		input logic empty, input logic lastw);
		drain_word_t w;
		w.ptime = ptime;
		w.plen = plen;
		w.data = data;
		w.wnum = wnum;
		w.vbytes = vbytes;
		w.empty = empty;
		w.lastw = lastw;
		w.pkt_cnt = pkt_total;
		w.byte_cnt = byte_total;
		expected_words.push_back(w);
	endtask

	task automatic capture_byte(input ring_item_t it);
		int base;
		int w;
		if (it.first) begin
			if (wr_slot + 5'd1 == rd_slot) begin
				dropping = 1'b1;
			end else begin
				dropping = 1'b0;
				target = (it.sig > MAX_BYTES) ? 9'(MAX_BYTES) : 9'(it.sig);
				fill = '0;
				ring_stamp[wr_slot] = it.stamp;
			end
		end
		if (dropping)
			return;
		base = int'(wr_slot) * WORDS_PER_SLOT;
		if (fill < target) begin
			if (fill[2:0] == 3'd0)
				ring_words[base + int'(fill[8:3])] = '0;
			ring_words[base + int'(fill[8:3])][fill[2:0] * 8 +: 8] = it.data;
			fill = fill + 9'd1;
		end
		if (it.last) begin
			// short frame: pad the remaining words with zeros
			for (w = (int'(fill) + 7) / 8; w < (int'(target) + 7) / 8; w++)
				ring_words[base + w] = '0;
			ring_len[wr_slot] = target;
			wr_slot = wr_slot + 5'd1;
			dropping = 1'b1;
		end
	endtask

	task automatic drain_packet();
		logic [8:0]  len;
		logic [31:0] stamp;
		logic [63:0] word;
		int nwords;
		int w;
		int vb;
		int base;
		if (rd_slot == wr_slot) begin
			push_word('0, '0, '0, '0, '0, 1'b1, 1'b1);
			return;
		end
		len = ring_len[rd_slot];
		stamp = ring_stamp[rd_slot];
		pkt_total = pkt_total + 32'd1;
		byte_total = byte_total + 32'(len);
		nwords = (int'(len) + 7) / 8;
		base = int'(rd_slot) * WORDS_PER_SLOT;
		if (nwords == 0) begin
			push_word(stamp, len, '0, '0, '0, 1'b0, 1'b1);
		end else begin
			for (w = 0; w < nwords; w++) begin
				vb = int'(len) - w * 8;
				if (vb > 8)
					vb = 8;
				word = ring_words[base + w];
				if (vb < 8)
					word = word & ((64'd1 << (vb * 8)) - 64'd1);
				push_word(stamp, len, word, 5'(w), 4'(vb), 1'b0, w + 1 == nwords);
			end
		end
		rd_slot = rd_slot + 5'd1;
	endtask

	task automatic apply_ring_item(input ring_item_t it);
		case (it.cmd)
			CMD_CAPTURE: capture_byte(it);
			CMD_DRAIN:   drain_packet();
			CMD_CLEAR:   clear_ring();
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
		input logic first, input logic last, input logic [11:0] sig,
		input logic [31:0] stamp);
		ring_item_t it;
		it.cmd = cmd;
		it.data = data;
		it.first = first;
		it.last = last;
		it.sig = sig;
		it.stamp = stamp;
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.data_byte <= data;
		req_ch.first_byte <= first;
		req_ch.last_byte <= last;
		req_ch.signal_length <= sig;
		req_ch.rx_time <= stamp;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_ring_item(it);
		items_sent++;
	endtask

	task automatic send_drain();
		send_item(CMD_DRAIN, 8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom),
			$urandom);
	endtask

	// Streams one frame; sig/time on later bytes are random, only the first counts.
	task automatic send_frame(input int sig, input int nbytes, input bit closed);
		logic [31:0] stamp;
		int i;
		stamp = $urandom;
		for (i = 0; i < nbytes; i++) begin
			if (i == 0)
				send_item(CMD_CAPTURE, 8'($urandom), 1'b1, closed && nbytes == 1, 12'(sig),
					stamp);
			else
				send_item(CMD_CAPTURE, 8'($urandom), 1'b0, closed && i == nbytes - 1,
					12'($urandom), $urandom);
		end
	endtask

	task automatic test_empty_drain();
		send_item(CMD_DRAIN, 8'h00, 1'b0, 1'b0, 12'h000, 32'h0000_0000);
		send_item(CMD_RESERVED, 8'hFF, 1'b1, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
		send_item(CMD_DRAIN, 8'hFF, 1'b1, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_single_byte();
		send_item(CMD_CAPTURE, 8'hFF, 1'b1, 1'b1, 12'd1, 32'hFFFF_FFFF);
		send_drain();
	endtask

	task automatic test_zero_length();
		send_item(CMD_CAPTURE, 8'h00, 1'b1, 1'b1, 12'd0, 32'h0000_0000);
		send_drain();
	endtask

	task automatic test_truncation();
		// oversize length with a short frame, then bytes past the stored length
		send_item(CMD_CAPTURE, 8'hA5, 1'b1, 1'b0, 12'hFFF, 32'h8000_0001);
		send_item(CMD_CAPTURE, 8'h5A, 1'b0, 1'b1, 12'h000, 32'h0000_0000);
		send_drain();
		send_item(CMD_CAPTURE, 8'h11, 1'b1, 1'b0, 12'd2, 32'h1234_5678);
		send_item(CMD_CAPTURE, 8'h22, 1'b0, 1'b0, 12'd2, 32'h0);
		send_item(CMD_CAPTURE, 8'h33, 1'b0, 1'b1, 12'd2, 32'h0);
		send_drain();
	endtask

	task automatic test_frame_restart();
		send_item(CMD_CAPTURE, 8'h77, 1'b0, 1'b1, 12'd5, 32'h5555_5555);
		send_item(CMD_CAPTURE, 8'h01, 1'b1, 1'b0, 12'd12, 32'hAAAA_AAAA);
		send_item(CMD_CAPTURE, 8'h02, 1'b0, 1'b0, 12'd12, 32'h0);
		send_frame(3, 3, 1'b1);
		send_drain();
	endtask

	task automatic test_clear();
		send_frame(3, 3, 1'b1);
		send_item(CMD_CLEAR, 8'h00, 1'b0, 1'b0, 12'd0, 32'h0);
		send_drain();
	endtask

	task automatic test_ring_full();
		int i;
		send_item(CMD_CLEAR, 8'($urandom), 1'b0, 1'b0, 12'd0, 32'h0);
		for (i = 0; i < SLOTS; i++)
			send_frame($urandom_range(1, 16), 1, 1'b1);
		send_frame(4, 4, 1'b1);
		for (i = 0; i < SLOTS + 1; i++)
			send_drain();
	endtask

	task automatic test_full_frame();
		send_frame($urandom_range(MAX_BYTES, 4095), 60, 1'b1);
		send_drain();
	endtask

	task automatic test_input_backpressure();
		int i;
		for (i = 0; i < 3; i++)
			send_frame(12, 12, 1'b1);
		hold_requests++;
		send_drain();
		send_frame(8, 8, 1'b1);
		for (i = 0; i < 4; i++)
			send_drain();
	endtask

	task automatic run_random_phase(input int count);
		int start;
		int r;
		int sig;
		int span;
		int kind;
		start = items_sent;
		while (items_sent - start < count) begin
			r = $urandom_range(99);
			if (r < 50) begin
				if ($urandom_range(19) == 0) begin
					send_frame($urandom_range(4095), $urandom_range(1, 6), 1'b1);
				end else begin
					sig = $urandom_range(24);
					span = (sig > 0) ? sig : 1;
					kind = $urandom_range(9);
					if (kind <= 6)
						send_frame(sig, span, 1'b1);
					else if (kind == 7)
						send_frame(sig, $urandom_range(1, span), 1'b1);
					else if (kind == 8)
						send_frame(sig, sig + $urandom_range(1, 4), 1'b1);
					else
						send_frame(sig, $urandom_range(1, span), 1'b0);
				end
			end else if (r < 85) begin
				send_drain();
			end else if (r < 88) begin
				send_item(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
					12'($urandom), $urandom);
			end else if (r < 94) begin
				send_item(CMD_CAPTURE, 8'($urandom), 1'b0, 1'($urandom), 12'($urandom),
					$urandom);
			end else begin
				send_item(CMD_RESERVED, 8'($urandom), 1'($urandom), 1'($urandom),
					12'($urandom), $urandom);
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_words
		drain_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got data %0h", $time,
					rsp_ch.word_data);
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("packet_time", want.ptime, rsp_ch.packet_time);
				check_field("packet_length", want.plen, rsp_ch.packet_length);
				check_field("word_data", want.data, rsp_ch.word_data);
				check_field("word_number", want.wnum, rsp_ch.word_number);
				check_field("valid_bytes", want.vbytes, rsp_ch.valid_bytes);
				check_field("ring_empty", want.empty, rsp_ch.ring_empty);
				check_field("last_word", want.lastw, rsp_ch.last_word);
				check_field("packet_total", want.pkt_cnt, rsp_ch.packet_total);
				check_field("byte_total", want.byte_cnt, rsp_ch.byte_total);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no handshake in %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_CAPTURE;
		req_ch.data_byte = '0;
		req_ch.first_byte = 1'b0;
		req_ch.last_byte = 1'b0;
		req_ch.signal_length = '0;
		req_ch.rx_time = '0;
		rsp_ch.ready = 1'b0;
		clear_ring();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_drain();
		test_single_byte();
		test_zero_length();
		test_truncation();
		test_frame_restart();
		test_clear();
		test_ring_full();

		gap_pct = 46;
		test_full_frame();
		gap_pct = 0;
		stall_pct = 20;
		test_input_backpressure();

		stall_pct = 0;
		run_random_phase(24);
		gap_pct = 46;
		run_random_phase(24);
		gap_pct = 0;
		stall_pct = 46;
		run_random_phase(24);
		gap_pct = 17;
		stall_pct = 17;
		run_random_phase(24);

		req_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[packet_capture_ring.f]
src/pcr_pkg.sv
src/pcr_if.sv
src/pcr_ctrl.sv
src/pcr_datapath.sv
src/packet_capture_ring.sv
bench/packet_capture_ring_test.sv
